FILE: rtl/core/assert_macros.svh
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/bsvr_pkg.sv
package bsvr_pkg;

    // default geometry
    localparam int DAC_BITS_DEF    = 12;
    localparam int OFFSET_BITS_DEF = 16;

    // field widths
    localparam int CODE_W     = 12;
    localparam int MEAS_W     = 16;
    localparam int TGT_W      = 13;
    localparam int BW_W       = 10;
    localparam int STEP_W     = 8;
    localparam int DZ_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int IN_W       = 32;

    // shared multiplier
    localparam int MUL_A_W = 22;
    localparam int MUL_B_W = 30;
    localparam int PROD_W  = 52;

    // target arithmetic: n = base - slope*code, num = n*(lin - 9n) - bias
    localparam logic signed [PROD_W-1:0]  LIN_BASE  = 52'sd1298432;
    localparam logic signed [MUL_B_W-1:0] LIN_SLOPE = 30'sd326;
    localparam logic signed [MUL_B_W:0]   QUAD_LIN  = 31'sd442327040;
    localparam logic signed [PROD_W-1:0]  QUAD_BIAS = 52'sd25318496665600;
    localparam logic [PROD_W-1:0]         DENOM_HALF = 52'd83886080000;
    localparam int                        QUOT_W    = 13;

    // rounding denominator is 625 * 2^28: shift first, then divide by 625
    // through ceil(2^31 / 625), exact for shifted magnitudes below 2^21
    localparam int                        DIV_SHIFT   = 28;
    localparam int                        DIV_IN_W    = 21;
    localparam logic signed [MUL_B_W-1:0] RECIP_625   = 30'sd3435974;
    localparam int                        RECIP_SHIFT = 31;

    // rise tracking
    localparam logic signed [TGT_W-1:0] RISE_COARSE = 13'sd10;
    localparam logic signed [TGT_W-1:0] RISE_FINE   = 13'sd11;

    // error path
    localparam int ERR_W   = 18;
    localparam int EMAG_W  = 17;
    localparam int STEPS_W = 3;
    localparam int DELTA_W = 10;

    // config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAND_WIDTH = 2'd0,
        CFG_STEP_HALF  = 2'd1,
        CFG_DEAD_ZONE  = 2'd2
    } t_cfg_idx;

    localparam logic [BW_W-1:0]   BW_RESET   = 10'd80;
    localparam logic [STEP_W-1:0] STEP_RESET = 8'd1;
    localparam logic [DZ_W-1:0]   DZ_RESET   = 7'd1;

    // sequencer
    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_LIN   = 12'b0000_0000_0010,
        S_TERM  = 12'b0000_0000_0100,
        S_QUAD  = 12'b0000_0000_1000,
        S_BIAS  = 12'b0000_0001_0000,
        S_ABS   = 12'b0000_0010_0000,
        S_DIV   = 12'b0000_0100_0000,
        S_TRACK = 12'b0000_1000_0000,
        S_ERR   = 12'b0001_0000_0000,
        S_BAND  = 12'b0010_0000_0000,
        S_OFS   = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    function automatic logic signed [PROD_W-1:0] mul(
        input logic signed [MUL_A_W-1:0] a,
        input logic signed [MUL_B_W-1:0] b
    );
        return PROD_W'(a) * PROD_W'(b);
    endfunction

endpackage

FILE: rtl/core/banded_step_voltage_regulator.sv
// Banded step voltage regulator. Each input beat carries a 12-bit setpoint code, the
// measured bus voltage in mV and a clear-offset flag; each yields exactly one output
// beat with the DAC drive code, a write strobe, the corrected target in cV and the
// fine indicator. The target is computed exactly: the code is mapped linearly, a
// quadratic correction is applied with one shared signed multiplier, and the result
// is rounded to centivolts by a shift and a reciprocal multiply on the same multiplier.
// Each item passes through the sequencer steps in order: linear map, term, quadratic
// product, bias and magnitude, then division, then rise tracking, error, banding,
// offset update and output load; the block then returns to idle, where it accepts
// the next item, so a new item is taken only after the last one is loaded. The chain
// of shared multiplier steps sets the item rate, and a previous output beat still
// waiting holds the output load step.
// The input is not ready while an item is in work; an output register holds the
// finished beat so the next item can be accepted before it is taken. Config writes
// are always accepted and must only be issued while the block is idle.
`include "assert_macros.svh"

module banded_step_voltage_regulator #(
    parameter int DAC_BITS    = bsvr_pkg::DAC_BITS_DEF,
    parameter int OFFSET_BITS = bsvr_pkg::OFFSET_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // input stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // setpoint_code[11:0], measured_mv[27:12], clear_offset[28], zero pad
    input  logic [bsvr_pkg::IN_W-1:0]            i_s_axis_tdata,

    // output stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // dac_code[DAC_BITS-1:0], target_cv[+13], fine_led[+1], zero pad
    output logic [((DAC_BITS+14+7)/8)*8-1:0]     o_m_axis_tdata,
    // dac_write
    output logic                                 o_m_axis_tuser,

    // config write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bsvr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bsvr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int OUT_W   = ((DAC_BITS + 14 + 7) / 8) * 8;
    localparam int DRV_W   = ((OFFSET_BITS > 14) ? OFFSET_BITS : 14) + 1;
    localparam int CMP_W   = ((DRV_W > DAC_BITS) ? DRV_W : DAC_BITS) + 1;
    localparam int SUM_W   = ((OFFSET_BITS > 11) ? OFFSET_BITS : 11) + 1;
    localparam longint OFS_HI_L = (longint'(1) << (OFFSET_BITS - 1)) - 1;
    localparam longint OFS_LO_L = -OFS_HI_L - 1;
    localparam logic signed [SUM_W-1:0] OFS_HI = SUM_W'(OFS_HI_L);
    localparam logic signed [SUM_W-1:0] OFS_LO = SUM_W'(OFS_LO_L);
    localparam logic [CMP_W-1:0] DAC_MAX = CMP_W'({DAC_BITS{1'b1}});

    // config registers
    logic [bsvr_pkg::BW_W-1:0]   r_band_width;
    logic [bsvr_pkg::STEP_W-1:0] r_step_half;
    logic [bsvr_pkg::DZ_W-1:0]   r_dead_zone;

    // control and kept state
    bsvr_pkg::t_state                   r_state,    n_state;
    logic                               r_out_valid, n_out_valid;
    logic signed [OFFSET_BITS-1:0]      r_offset,   n_offset;
    logic signed [bsvr_pkg::TGT_W-1:0]  r_prev,     n_prev;
    logic signed [bsvr_pkg::TGT_W-1:0]  r_last_rise, n_last_rise;
    logic                               r_led,      n_led;

    // payload
    logic [bsvr_pkg::CODE_W-1:0]        r_code,     n_code;
    logic [bsvr_pkg::MEAS_W-1:0]        r_meas,     n_meas;
    logic signed [bsvr_pkg::MUL_A_W-1:0] r_n,       n_n;
    logic signed [bsvr_pkg::MUL_B_W-1:0] r_t,       n_t;
    logic [bsvr_pkg::PROD_W-1:0]        r_acc,      n_acc;
    logic                               r_neg,      n_neg;
    logic [bsvr_pkg::QUOT_W-1:0]        r_q,        n_q;
    logic signed [bsvr_pkg::TGT_W-1:0]  r_tgt,      n_tgt;
    logic signed [bsvr_pkg::ERR_W-1:0]  r_err,      n_err;
    logic [bsvr_pkg::EMAG_W-1:0]        r_emag,     n_emag;
    logic                               r_wr,       n_wr;
    logic [bsvr_pkg::STEPS_W-1:0]       r_steps,    n_steps;
    logic [DAC_BITS-1:0]                r_out_dac,  n_out_dac;
    logic                               r_out_wr,   n_out_wr;
    logic signed [bsvr_pkg::TGT_W-1:0]  r_out_tgt,  n_out_tgt;
    logic                               r_out_led,  n_out_led;

    // shared multiplier
    logic signed [bsvr_pkg::MUL_A_W-1:0] mul_a;
    logic signed [bsvr_pkg::MUL_B_W-1:0] mul_b;
    logic signed [bsvr_pkg::PROD_W-1:0]  prod;

    logic in_accept;
    logic out_free;

    // datapath temporaries
    logic signed [bsvr_pkg::MUL_B_W:0]  n9;
    logic signed [bsvr_pkg::TGT_W-1:0]  tgt_raw;
    logic signed [bsvr_pkg::ERR_W-1:0]  err;
    logic [bsvr_pkg::EMAG_W-1:0]        bw1, bw5, bw6, bw7, bw8;
    logic [bsvr_pkg::DELTA_W-1:0]       delta;
    logic signed [SUM_W-1:0]            ofs_sum;
    logic signed [DRV_W-1:0]            drive;
    logic [CMP_W-1:0]                   drive_half;

    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == bsvr_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_wr;
    assign o_m_axis_tdata  = OUT_W'({r_out_led, r_out_tgt, r_out_dac});

    // band edges as multiples of the band width
    assign bw1 = bsvr_pkg::EMAG_W'(r_band_width);
    assign bw5 = (bw1 << 2) + bw1;
    assign bw6 = (bw1 << 2) + (bw1 << 1);
    assign bw7 = (bw1 << 3) - bw1;
    assign bw8 = bw1 << 3;

    // multiplier operand select by sequencer step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            bsvr_pkg::S_LIN: begin
                mul_a = bsvr_pkg::MUL_A_W'({1'b0, r_code});
                mul_b = bsvr_pkg::LIN_SLOPE;
            end
            bsvr_pkg::S_QUAD: begin
                mul_a = r_n;
                mul_b = r_t;
            end
            bsvr_pkg::S_DIV: begin
                // magnitude over 2^28 times the reciprocal of 625
                mul_a = bsvr_pkg::MUL_A_W'({1'b0,
                        r_acc[bsvr_pkg::DIV_SHIFT+bsvr_pkg::DIV_IN_W-1:bsvr_pkg::DIV_SHIFT]});
                mul_b = bsvr_pkg::RECIP_625;
            end
            bsvr_pkg::S_ERR: begin
                mul_a = bsvr_pkg::MUL_A_W'(r_tgt);
                mul_b = bsvr_pkg::MUL_B_W'(10);
            end
            bsvr_pkg::S_OFS: begin
                mul_a = bsvr_pkg::MUL_A_W'({1'b0, r_steps});
                mul_b = bsvr_pkg::MUL_B_W'({1'b0, r_step_half});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = bsvr_pkg::mul(mul_a, mul_b);
    end

    // sequencer and datapath
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_offset    = r_offset;
        n_prev      = r_prev;
        n_last_rise = r_last_rise;
        n_led       = r_led;
        n_code      = r_code;
        n_meas      = r_meas;
        n_n         = r_n;
        n_t         = r_t;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_q         = r_q;
        n_tgt       = r_tgt;
        n_err       = r_err;
        n_emag      = r_emag;
        n_wr        = r_wr;
        n_steps     = r_steps;
        n_out_dac   = r_out_dac;
        n_out_wr    = r_out_wr;
        n_out_tgt   = r_out_tgt;
        n_out_led   = r_out_led;

        n9         = (bsvr_pkg::MUL_B_W'(r_n) <<< 3) + (bsvr_pkg::MUL_B_W + 1)'(r_n);
        tgt_raw    = r_neg ? -$signed(r_q) : $signed(r_q);
        err        = bsvr_pkg::ERR_W'(prod) - bsvr_pkg::ERR_W'($signed({1'b0, r_meas}));
        delta      = prod[bsvr_pkg::DELTA_W-1:0];
        ofs_sum    = r_err[bsvr_pkg::ERR_W-1]
                   ? SUM_W'(r_offset) + SUM_W'($signed({1'b0, delta}))
                   : SUM_W'(r_offset) - SUM_W'($signed({1'b0, delta}));
        drive      = DRV_W'($signed({1'b0, r_code, 1'b0})) + DRV_W'(r_offset);
        drive_half = CMP_W'(drive[DRV_W-2:1]);

        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bsvr_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_code  = i_s_axis_tdata[11:0];
                    n_meas  = i_s_axis_tdata[27:12];
                    if (i_s_axis_tdata[28]) begin
                        n_offset = '0;
                    end
                    n_state = bsvr_pkg::S_LIN;
                end
            end
            bsvr_pkg::S_LIN: begin
                // n = base - 326*code
                n_n     = bsvr_pkg::MUL_A_W'(bsvr_pkg::LIN_BASE - prod);
                n_state = bsvr_pkg::S_TERM;
            end
            bsvr_pkg::S_TERM: begin
                n_t     = bsvr_pkg::MUL_B_W'(bsvr_pkg::QUAD_LIN - n9);
                n_state = bsvr_pkg::S_QUAD;
            end
            bsvr_pkg::S_QUAD: begin
                n_acc   = prod;
                n_state = bsvr_pkg::S_BIAS;
            end
            bsvr_pkg::S_BIAS: begin
                n_acc   = r_acc - bsvr_pkg::QUAD_BIAS;
                n_state = bsvr_pkg::S_ABS;
            end
            bsvr_pkg::S_ABS: begin
                // round half away from zero on the magnitude
                n_neg   = r_acc[bsvr_pkg::PROD_W-1];
                n_acc   = (r_acc[bsvr_pkg::PROD_W-1] ? -r_acc : r_acc)
                        + bsvr_pkg::DENOM_HALF;
                n_state = bsvr_pkg::S_DIV;
            end
            bsvr_pkg::S_DIV: begin
                // quotient sits above the reciprocal's fraction bits
                n_q     = prod[bsvr_pkg::RECIP_SHIFT+bsvr_pkg::QUOT_W-1:bsvr_pkg::RECIP_SHIFT];
                n_state = bsvr_pkg::S_TRACK;
            end
            bsvr_pkg::S_TRACK: begin
                if (tgt_raw > r_prev) begin
                    n_last_rise = tgt_raw - r_prev;
                end
                n_prev = tgt_raw;
                n_tgt  = tgt_raw;
                if (n_last_rise == bsvr_pkg::RISE_COARSE) begin
                    n_led = 1'b0;
                end else if (n_last_rise == bsvr_pkg::RISE_FINE) begin
                    n_led = 1'b1;
                    n_tgt = tgt_raw - 1'b1;
                end
                n_state = bsvr_pkg::S_ERR;
            end
            bsvr_pkg::S_ERR: begin
                // error = target*10 - measured
                n_err   = err;
                n_wr    = (err != '0);
                n_emag  = bsvr_pkg::EMAG_W'(err[bsvr_pkg::ERR_W-1] ? -err : err);
                n_state = bsvr_pkg::S_BAND;
            end
            bsvr_pkg::S_BAND: begin
                if (r_emag <= bw1) begin
                    n_steps = (r_emag >= bsvr_pkg::EMAG_W'(r_dead_zone)) ? 3'd1 : 3'd0;
                end else if (r_emag <= bw5) begin
                    n_steps = 3'd1;
                end else if (r_emag <= bw6) begin
                    n_steps = 3'd2;
                end else if (r_emag <= bw7) begin
                    n_steps = 3'd3;
                end else if (r_emag <= bw8) begin
                    n_steps = 3'd4;
                end else begin
                    n_steps = 3'd0;
                end
                n_state = bsvr_pkg::S_OFS;
            end
            bsvr_pkg::S_OFS: begin
                // move against the error sign, saturate
                if (r_wr) begin
                    if (ofs_sum > OFS_HI) begin
                        n_offset = OFFSET_BITS'(OFS_HI);
                    end else if (ofs_sum < OFS_LO) begin
                        n_offset = OFFSET_BITS'(OFS_LO);
                    end else begin
                        n_offset = OFFSET_BITS'(ofs_sum);
                    end
                end
                n_state = bsvr_pkg::S_OUT;
            end
            bsvr_pkg::S_OUT: begin
                if (out_free) begin
                    if (drive[DRV_W-1]) begin
                        n_out_dac = '0;
                    end else if (drive_half > DAC_MAX) begin
                        n_out_dac = DAC_MAX[DAC_BITS-1:0];
                    end else begin
                        n_out_dac = drive_half[DAC_BITS-1:0];
                    end
                    n_out_wr    = r_wr;
                    n_out_tgt   = r_tgt;
                    n_out_led   = r_led;
                    n_out_valid = 1'b1;
                    n_state     = bsvr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsvr_pkg::S_IDLE;
            end
        endcase
    end

    // control state and config, synchronous reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bsvr_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_offset     <= '0;
            r_prev       <= '0;
            r_last_rise  <= '0;
            r_led        <= 1'b0;
            r_band_width <= bsvr_pkg::BW_RESET;
            r_step_half  <= bsvr_pkg::STEP_RESET;
            r_dead_zone  <= bsvr_pkg::DZ_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_offset    <= n_offset;
            r_prev      <= n_prev;
            r_last_rise <= n_last_rise;
            r_led       <= n_led;
            if (i_cfg_valid) begin
                case (bsvr_pkg::t_cfg_idx'(i_cfg_index))
                    bsvr_pkg::CFG_BAND_WIDTH: r_band_width <= i_cfg_data;
                    bsvr_pkg::CFG_STEP_HALF:  r_step_half  <= i_cfg_data[bsvr_pkg::STEP_W-1:0];
                    bsvr_pkg::CFG_DEAD_ZONE:  r_dead_zone  <= i_cfg_data[bsvr_pkg::DZ_W-1:0];
                    default: begin
                        // unmapped index, ignored
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_code    <= n_code;
        r_meas    <= n_meas;
        r_n       <= n_n;
        r_t       <= n_t;
        r_acc     <= n_acc;
        r_neg     <= n_neg;
        r_q       <= n_q;
        r_tgt     <= n_tgt;
        r_err     <= n_err;
        r_emag    <= n_emag;
        r_wr      <= n_wr;
        r_steps   <= n_steps;
        r_out_dac <= n_out_dac;
        r_out_wr  <= n_out_wr;
        r_out_tgt <= n_out_tgt;
        r_out_led <= n_out_led;
    end

    // an accepted beat always starts the linear map
    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_accept, r_state == bsvr_pkg::S_LIN)

    // the division takes a single step
    `ASSERT_NEXT(a_div_exit, i_clk, i_rst_n,
        r_state == bsvr_pkg::S_DIV, r_state == bsvr_pkg::S_TRACK)

    // the offset moves only on a clear at accept or in the update step
    `ASSERT_NEXT(a_offset_hold, i_clk, i_rst_n,
        !in_accept && (r_state != bsvr_pkg::S_OFS), $stable(r_offset))

    // a loaded output beat carries the current indicator and strobe
    `ASSERT_NEXT(a_out_load, i_clk, i_rst_n,
        (r_state == bsvr_pkg::S_OUT) && out_free,
        o_m_axis_tvalid && (r_out_led == r_led) && (o_m_axis_tuser == r_wr))

endmodule
